@@ rtl/mphp_pkg.sv @@
// mphp_pkg: shared types and codes for the mesh packet header parser
// item payload structs, register file struct, parser state and code constants
// no dependencies
`timescale 1ns / 1ps

package mphp_pkg;

  // number of transport-code bytes after a transport route header
  localparam logic [7:0] TRANSPORT_BYTES = 8'd4;

  // configuration register indexes
  localparam logic [2:0] REG_ROUTE_MASK     = 3'd0;
  localparam logic [2:0] REG_FLOOD_CODE     = 3'd1;
  localparam logic [2:0] REG_DIRECT_CODE    = 3'd2;
  localparam logic [2:0] REG_TYPE_SHIFT     = 3'd3;
  localparam logic [2:0] REG_TYPE_MASK      = 3'd4;
  localparam logic [2:0] REG_MAX_PATH_LEN   = 3'd5;
  localparam logic [2:0] REG_MAX_PAYLOAD    = 3'd6;

  // byte roles
  localparam logic [2:0] ROLE_HEADER    = 3'd0;
  localparam logic [2:0] ROLE_TRANSPORT = 3'd1;
  localparam logic [2:0] ROLE_PATH_LEN  = 3'd2;
  localparam logic [2:0] ROLE_PATH      = 3'd3;
  localparam logic [2:0] ROLE_PAYLOAD   = 3'd4;
  localparam logic [2:0] ROLE_DISCARD   = 3'd5;

  // packet status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_TRUNC_HEADER  = 3'd1;
  localparam logic [2:0] ST_PATH_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_PATH_TRUNC    = 3'd3;
  localparam logic [2:0] ST_NO_PAYLOAD    = 3'd4;
  localparam logic [2:0] ST_PAYLOAD_LONG  = 3'd5;

  typedef enum logic [5:0] {
    PH_HEADER    = 6'b000001,
    PH_TRANSPORT = 6'b000010,
    PH_PATHLEN   = 6'b000100,
    PH_PATH      = 6'b001000,
    PH_PAYLOAD   = 6'b010000,
    PH_DISCARD   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] role;
    logic [7:0] field_offset;
    logic [7:0] route_type;
    logic [7:0] payload_type;
    logic       has_transport;
    logic       packet_end;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] route_mask;
    logic [7:0] flood_transport_code;
    logic [7:0] direct_transport_code;
    logic [2:0] type_shift;
    logic [7:0] type_mask;
    logic [7:0] max_path_len;
    logic [7:0] max_payload_len;
  } cfg_regs_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] field_count;
    logic [7:0] path_length;
    logic [7:0] payload_count;
    logic [7:0] header_byte;
    logic [2:0] error_code;
  } parse_state_t;

endpackage

@@ rtl/mphp_step.sv @@
// mphp_step: per-byte parse logic, next parser state and tagged result item
// depends on mphp_pkg
`timescale 1ns / 1ps

module mphp_step (
  input  mphp_pkg::parse_state_t cur,
  input  mphp_pkg::in_item_t     item,
  input  mphp_pkg::cfg_regs_t    cfg,
  output mphp_pkg::parse_state_t nxt,
  output mphp_pkg::out_item_t    res
);
  import mphp_pkg::*;

  logic [7:0] hdr;
  logic [7:0] rt;
  logic [7:0] pt;
  logic       trans;
  logic [8:0] count_inc;
  logic [2:0] role;
  logic [7:0] offset;
  logic [2:0] status;
  parse_state_t upd;

  // header byte comes straight from the input while in header phase
  assign hdr   = (cur.phase == PH_HEADER) ? item.byte_in : cur.header_byte;
  assign rt    = hdr & cfg.route_mask;
  assign pt    = (hdr >> cfg.type_shift) & cfg.type_mask;
  assign trans = (rt == cfg.flood_transport_code) || (rt == cfg.direct_transport_code);
  assign count_inc = {1'b0, cur.field_count} + 9'd1;

  always_comb begin
    upd = cur;
    upd.header_byte = hdr;
    role   = ROLE_DISCARD;
    offset = 8'd0;
    status = ST_OK;
    unique case (cur.phase)
      PH_HEADER: begin
        role = ROLE_HEADER;
        upd.field_count = 8'd0;
        upd.phase = trans ? PH_TRANSPORT : PH_PATHLEN;
        status = ST_TRUNC_HEADER;
      end
      PH_TRANSPORT: begin
        role   = ROLE_TRANSPORT;
        offset = cur.field_count;
        status = ST_TRUNC_HEADER;
        if (count_inc >= {1'b0, TRANSPORT_BYTES}) begin
          upd.field_count = 8'd0;
          upd.phase = PH_PATHLEN;
        end else begin
          upd.field_count = count_inc[7:0];
        end
      end
      PH_PATHLEN: begin
        role = ROLE_PATH_LEN;
        upd.path_length = item.byte_in;
        upd.field_count = 8'd0;
        if (item.byte_in > cfg.max_path_len) begin
          upd.error_code = ST_PATH_TOO_LONG;
          upd.phase = PH_DISCARD;
          status = ST_PATH_TOO_LONG;
        end else if (item.byte_in == 8'd0) begin
          upd.phase = PH_PAYLOAD;
          status = ST_NO_PAYLOAD;
        end else begin
          upd.phase = PH_PATH;
          status = ST_PATH_TRUNC;
        end
      end
      PH_PATH: begin
        role   = ROLE_PATH;
        offset = cur.field_count;
        upd.field_count = count_inc[7:0];
        if (count_inc >= {1'b0, cur.path_length}) begin
          upd.phase = PH_PAYLOAD;
          status = ST_NO_PAYLOAD;
        end else begin
          status = ST_PATH_TRUNC;
        end
      end
      PH_PAYLOAD: begin
        if (cur.payload_count >= cfg.max_payload_len) begin
          upd.error_code = ST_PAYLOAD_LONG;
          upd.phase = PH_DISCARD;
          role = ROLE_DISCARD;
        end else begin
          role   = ROLE_PAYLOAD;
          offset = cur.payload_count;
          upd.payload_count = cur.payload_count + 8'd1;
        end
        status = upd.error_code;
      end
      default: begin
        role   = ROLE_DISCARD;
        status = cur.error_code;
      end
    endcase

    // end of packet returns every field to its reset value
    if (item.last_byte) begin
      nxt.phase         = PH_HEADER;
      nxt.field_count   = 8'd0;
      nxt.path_length   = 8'd0;
      nxt.payload_count = 8'd0;
      nxt.header_byte   = 8'd0;
      nxt.error_code    = ST_OK;
    end else begin
      nxt = upd;
    end

    res.byte_out      = item.byte_in;
    res.role          = role;
    res.field_offset  = offset;
    res.route_type    = rt;
    res.payload_type  = pt;
    res.has_transport = trans;
    res.packet_end    = item.last_byte;
    res.status        = item.last_byte ? status : ST_OK;
  end

endmodule

@@ rtl/mesh_packet_header_parser_unit.sv @@
// mesh_packet_header_parser_unit: top level of the mesh packet header parser
// depends on mphp_pkg and mphp_step
//
// channel  | dir | handshake          | payload
// in_      | in  | in_valid/in_stall  | in_data  (byte_in, last_byte)
// out_     | out | out_valid/out_stall| out_data (byte_out, role, offset, types, status)
// cfg_     | in  | cfg_valid/cfg_ready| cfg_index (3b), cfg_data (8b)
//
// one item per cycle sustained while out_stall is low; an accepted item passes
// through the input register and then the result register:
// an input register feeds the single-pass parse logic, which loads the result
// register and updates the parser state in the same cycle.
// rst_n is synchronous: clears valids, parser state and config registers to defaults.
// a stalled result holds the input register; in_stall rises only when both
// the input register and the result register are occupied and out_stall is high.
// cfg_ready is always high, a write to an unknown index is dropped
`timescale 1ns / 1ps

module mesh_packet_header_parser_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte stream in
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mphp_pkg::in_item_t    in_data,
  // tagged byte stream out
  output logic                  out_valid,
  input  logic                  out_stall,
  output mphp_pkg::out_item_t   out_data,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [7:0]            cfg_data
);
  import mphp_pkg::*;

  // input register
  logic         in_valid_r, in_valid_nxt;
  in_item_t     in_item_r;
  // result register
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_item_r;
  // parser state and register file
  parse_state_t state_r, state_nxt;
  cfg_regs_t    cfg_r, cfg_nxt;

  out_item_t    step_res;
  logic         in_take;
  logic         advance;

  // the parse step fires when the input register holds an item and the result register is free or draining
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign cfg_ready = 1'b1;

  mphp_step u_step (
    .cur  (state_r),
    .item (in_item_r),
    .cfg  (cfg_r),
    .nxt  (state_nxt),
    .res  (step_res)
  );

  always_comb begin
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end

    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // register file write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROUTE_MASK:   cfg_nxt.route_mask            = cfg_data;
        REG_FLOOD_CODE:   cfg_nxt.flood_transport_code  = cfg_data;
        REG_DIRECT_CODE:  cfg_nxt.direct_transport_code = cfg_data;
        REG_TYPE_SHIFT:   cfg_nxt.type_shift            = cfg_data[2:0];
        REG_TYPE_MASK:    cfg_nxt.type_mask             = cfg_data;
        REG_MAX_PATH_LEN: cfg_nxt.max_path_len          = cfg_data;
        REG_MAX_PAYLOAD:  cfg_nxt.max_payload_len       = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // control state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r.phase         <= PH_HEADER;
      state_r.field_count   <= 8'd0;
      state_r.path_length   <= 8'd0;
      state_r.payload_count <= 8'd0;
      state_r.header_byte   <= 8'd0;
      state_r.error_code    <= ST_OK;
      cfg_r.route_mask            <= 8'd3;
      cfg_r.flood_transport_code  <= 8'd0;
      cfg_r.direct_transport_code <= 8'd3;
      cfg_r.type_shift            <= 3'd2;
      cfg_r.type_mask             <= 8'd15;
      cfg_r.max_path_len          <= 8'd64;
      cfg_r.max_payload_len       <= 8'd184;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= step_res;
    end
  end

endmodule
